// File: rtl/fpwb_pkg.sv
package fpwb_pkg;

  // Page geometry of the modeled flash array.
  localparam int PageBytes  = 256;
  localparam int PageCount  = 64;
  localparam int OffW       = $clog2(PageBytes);
  localparam int PageW      = $clog2(PageCount);
  localparam int FlashDepth = PageBytes * PageCount;
  localparam int FlashAw    = OffW + PageW;

  // Field widths of the stream words.
  localparam int OpW       = 2;
  localparam int AddrW     = 14;
  localparam int DataW     = 8;
  localparam int InTdataW  = 24;
  localparam int OutFieldW = DataW + 3 + PageW;
  localparam int OutTdataW = 24;

  // Erased flash byte.
  localparam logic [DataW-1:0] ErasedByte = '1;

  // Operation codes carried in the input tuser.
  typedef enum logic [OpW-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_run;
    logic load_in;
    logic hit_cap;
    logic rd_cap;
    logic wb_start;
    logic wb_run;
    logic ld_start;
    logic ld_run;
    logic drop;
    logic upd_wr;
    logic res_push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic           clr_last;
    logic           sweep_last;
    logic           hit;
    logic           buf_valid;
    logic           held_zero;
    logic           dirty;
    logic           out_free;
    logic [OpW-1:0] op;
  } sts_t;

endpackage

// File: rtl/flash_page_write_back_buffer.sv
// Channel   Direction  Ports                    Payload
// s_axis    in         tvalid, tready, tdata,   tdata: byte_address, write_data
//                      tuser                    tuser: opcode
// m_axis    out        tvalid, tready, tdata    tdata: read_data, page_erased,
//                                               page_programmed, changes_dropped,
//                                               affected_page
//
// One word is worked on at a time. A read passes S_DECODE, S_RDCAP and S_DONE before the
// result register is loaded, a write to the held page S_UPD_WR in place of S_RDCAP, and a
// clean flush or an unknown opcode S_DECODE and S_DONE only; the next word is taken in the
// cycle after the push. A write-back and a page load each sweep the page at one byte a
// cycle. After reset a clearing pass writes all 16384 flash bytes to 0xFF before any word
// is taken. A stalled result holds back the next word only once that word's result is ready.
module flash_page_write_back_buffer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [13:0] byte_address, [21:14] write_data, [23:22] zero
  input  logic [fpwb_pkg::InTdataW-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [fpwb_pkg::OpW-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data, [8] page_erased, [9] page_programmed,
  // [10] changes_dropped, [16:11] affected_page, [23:17] zero
  output logic [fpwb_pkg::OutTdataW-1:0]   m_axis_tdata
);

  fpwb_pkg::cmd_t cmd;
  fpwb_pkg::sts_t sts;

  fpwb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  fpwb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // A dropped page is never also programmed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[9]))
    else $error("dropped page reported as programmed");

  // An erase only happens as part of programming the page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[9])
    else $error("erase reported without programming");

  // Dropped changes always belong to page zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[16:11] == '0)
    else $error("dropped page is not page zero");

  // One word at a time: acceptance closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while busy");

endmodule

// File: rtl/fpwb_ram.sv
module fpwb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fpwb_ctrl.sv
module fpwb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  fpwb_pkg::sts_t      sts_i,
  output fpwb_pkg::cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_RDCAP  = 9'b000001000,
    S_WB     = 9'b000010000,
    S_LOAD   = 9'b000100000,
    S_UPD_RD = 9'b001000000,
    S_UPD_WR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        // Both memories are read at the item's address in this cycle.
        cmd_o.hit_cap = 1'b1;
        case (sts_i.op)
          fpwb_pkg::OP_READ: begin
            state_d = S_RDCAP;
          end
          fpwb_pkg::OP_WRITE: begin
            if (sts_i.hit) begin
              state_d = S_UPD_WR;
            end else if (sts_i.buf_valid && sts_i.held_zero) begin
              cmd_o.drop     = 1'b1;
              cmd_o.ld_start = 1'b1;
              state_d        = S_LOAD;
            end else if (sts_i.buf_valid && sts_i.dirty) begin
              cmd_o.wb_start = 1'b1;
              state_d        = S_WB;
            end else begin
              cmd_o.ld_start = 1'b1;
              state_d        = S_LOAD;
            end
          end
          fpwb_pkg::OP_FLUSH: begin
            if (sts_i.buf_valid && sts_i.dirty) begin
              cmd_o.wb_start = 1'b1;
              state_d        = S_WB;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RDCAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_DONE;
      end
      S_WB: begin
        cmd_o.wb_run = 1'b1;
        if (sts_i.sweep_last) begin
          if (sts_i.op == fpwb_pkg::OP_WRITE) begin
            cmd_o.ld_start = 1'b1;
            state_d        = S_LOAD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.ld_run = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the flash clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/fpwb_dp.sv
module fpwb_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [fpwb_pkg::InTdataW-1:0]        s_axis_tdata,
  input  logic [fpwb_pkg::OpW-1:0]             s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fpwb_pkg::OutTdataW-1:0]       m_axis_tdata,
  input  fpwb_pkg::cmd_t                       cmd_i,
  output fpwb_pkg::sts_t                       sts_o
);

  // Latched input word.
  logic [fpwb_pkg::OpW-1:0]   op_q;
  logic [fpwb_pkg::AddrW-1:0] addr_q;
  logic [fpwb_pkg::DataW-1:0] data_q;

  // Buffer bookkeeping.
  logic [fpwb_pkg::PageW-1:0] held_q;
  logic                       valid_q, dirty_q, erase_q, hit_q;

  // Sweep counters.
  logic [fpwb_pkg::OffW:0]     cnt_q, cnt_m1;
  logic [fpwb_pkg::FlashAw-1:0] clr_q;

  // Result being built and the output register.
  logic [fpwb_pkg::DataW-1:0] res_rd_q;
  logic                       res_er_q, res_pg_q, res_drop_q;
  logic [fpwb_pkg::PageW-1:0] res_page_q;
  logic                       out_valid_q;
  logic [fpwb_pkg::OutTdataW-1:0] out_data_q;

  // Memory ports.
  logic                         fl_we, bf_we;
  logic [fpwb_pkg::FlashAw-1:0] fl_waddr, fl_raddr;
  logic [fpwb_pkg::DataW-1:0]   fl_wdata, fl_rdata;
  logic [fpwb_pkg::OffW-1:0]    bf_waddr, bf_raddr;
  logic [fpwb_pkg::DataW-1:0]   bf_wdata, bf_rdata;

  logic [fpwb_pkg::PageW-1:0] page_in;
  logic [fpwb_pkg::OffW-1:0]  off_in;
  logic                       sweep_wr;

  assign page_in  = addr_q[fpwb_pkg::OffW +: fpwb_pkg::PageW];
  assign off_in   = addr_q[fpwb_pkg::OffW-1:0];
  assign cnt_m1   = cnt_q - (fpwb_pkg::OffW+1)'(1);
  assign sweep_wr = (cnt_q != '0);

  // Flash port: clearing pass, write-back sweep, page load read sweep, or single byte read.
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = {held_q, cnt_m1[fpwb_pkg::OffW-1:0]};
    fl_wdata = res_er_q ? bf_rdata : (fl_rdata & bf_rdata);
    if (cmd_i.clr_run) begin
      fl_we    = 1'b1;
      fl_waddr = clr_q;
      fl_wdata = fpwb_pkg::ErasedByte;
    end else if (cmd_i.wb_run) begin
      fl_we = sweep_wr;
    end
    if (cmd_i.wb_run || cmd_i.ld_run) begin
      fl_raddr = {held_q, cnt_q[fpwb_pkg::OffW-1:0]};
    end else begin
      fl_raddr = {page_in, off_in};
    end
  end

  // Buffer port: page load sweep, write-back read sweep, or the single byte update.
  always_comb begin
    bf_we    = 1'b0;
    bf_waddr = off_in;
    bf_wdata = data_q;
    if (cmd_i.ld_run) begin
      bf_we    = sweep_wr;
      bf_waddr = cnt_m1[fpwb_pkg::OffW-1:0];
      bf_wdata = fl_rdata;
    end else if (cmd_i.upd_wr) begin
      bf_we = 1'b1;
    end
    bf_raddr = cmd_i.wb_run ? cnt_q[fpwb_pkg::OffW-1:0] : off_in;
  end

  fpwb_ram #(
    .Width (fpwb_pkg::DataW),
    .Depth (fpwb_pkg::FlashDepth)
  ) u_flash (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  fpwb_ram #(
    .Width (fpwb_pkg::DataW),
    .Depth (fpwb_pkg::PageBytes)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .raddr_i (bf_raddr),
    .rdata_o (bf_rdata)
  );

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      addr_q <= s_axis_tdata[fpwb_pkg::AddrW-1:0];
      data_q <= s_axis_tdata[fpwb_pkg::AddrW +: fpwb_pkg::DataW];
      op_q   <= s_axis_tuser;
    end
    if (cmd_i.hit_cap) begin
      hit_q <= valid_q && (held_q == page_in);
    end
  end

  // Buffer state, sweep counters and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      valid_q    <= 1'b0;
      dirty_q    <= 1'b0;
      erase_q    <= 1'b0;
      cnt_q      <= '0;
      clr_q      <= '0;
      res_rd_q   <= '0;
      res_er_q   <= 1'b0;
      res_pg_q   <= 1'b0;
      res_drop_q <= 1'b0;
      res_page_q <= '0;
    end else begin
      if (cmd_i.clr_run) begin
        clr_q <= clr_q + fpwb_pkg::FlashAw'(1);
      end
      if (cmd_i.load_in) begin
        res_rd_q   <= '0;
        res_er_q   <= 1'b0;
        res_pg_q   <= 1'b0;
        res_drop_q <= 1'b0;
        res_page_q <= '0;
      end
      if (cmd_i.rd_cap) begin
        res_rd_q <= hit_q ? bf_rdata : fl_rdata;
      end
      if (cmd_i.drop) begin
        res_drop_q <= 1'b1;
        res_page_q <= '0;
      end
      // A sweep start restarts the counter, even on the last write-back cycle.
      if (cmd_i.wb_start || cmd_i.ld_start) begin
        cnt_q <= '0;
      end else if (cmd_i.wb_run || cmd_i.ld_run) begin
        cnt_q <= cnt_q + (fpwb_pkg::OffW+1)'(1);
      end
      // Write-back keeps its erase decision in the result flag for the sweep.
      if (cmd_i.wb_start) begin
        res_er_q   <= erase_q;
        res_pg_q   <= 1'b1;
        res_page_q <= held_q;
        dirty_q    <= 1'b0;
        erase_q    <= 1'b0;
      end
      if (cmd_i.ld_start) begin
        held_q  <= page_in;
        valid_q <= 1'b1;
        dirty_q <= 1'b0;
        erase_q <= 1'b0;
      end
      // Byte update: note any bit that must rise, and any change at all.
      if (cmd_i.upd_wr) begin
        if ((data_q & ~bf_rdata) != '0) begin
          erase_q <= 1'b1;
        end
        if (data_q != bf_rdata) begin
          dirty_q <= 1'b1;
        end
      end
    end
  end

  // Output register; it frees up in the cycle its word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_push) begin
      out_data_q <= {(fpwb_pkg::OutTdataW - fpwb_pkg::OutFieldW)'(0),
                     res_page_q, res_drop_q, res_pg_q, res_er_q, res_rd_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (clr_q == '1);
    sts_o.sweep_last = (cnt_q == (fpwb_pkg::OffW+1)'(fpwb_pkg::PageBytes));
    sts_o.hit        = valid_q && (held_q == page_in);
    sts_o.buf_valid  = valid_q;
    sts_o.held_zero  = (held_q == '0);
    sts_o.dirty      = dirty_q;
    sts_o.out_free   = !out_valid_q || m_axis_tready;
    sts_o.op         = op_q;
  end

endmodule

// File: tb/tb_flash_page_write_back_buffer.sv
`timescale 1ns / 100ps

module tb_flash_page_write_back_buffer;
  import fpwb_pkg::*;

  localparam int ClkHalf      = 4;
  localparam int ResetCycles  = 11;
  localparam int RandomItems  = 1200;
  localparam int MaxIdle      = 6;
  // Covers the clearing pass after reset with a wide margin.
  localparam int IdleLimit    = 80000;
  localparam int LongHold     = 400;
  localparam int TailCycles   = 3 * (PageBytes + 1) + 16;

  // The one opcode value with no operation behind it.
  localparam logic [OpW-1:0] OpUnknown = 2'd3;

  // Result word as it sits in m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [OutTdataW-OutFieldW-1:0] pad;
    logic [PageW-1:0]               page;
    logic                           dropped;
    logic                           programmed;
    logic                           erased;
    logic [DataW-1:0]               read_data;
  } flash_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic             typed;
    flash_result_t    want;
  } stim_row_t;

  function automatic flash_result_t outcome(logic [DataW-1:0] rd, logic dr,
                                            logic [PageW-1:0] pg);
    outcome           = '0;
    outcome.read_data = rd;
    outcome.dropped   = dr;
    outcome.page      = pg;
  endfunction

  localparam int DirectedCount = 25;
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{OP_READ,   14'h0000, 8'h00, 1'b1, outcome(8'hFF, 1'b0, 6'd0)},
    '{OP_READ,   14'h3FFF, 8'h00, 1'b1, outcome(8'hFF, 1'b0, 6'd0)},
    '{OP_FLUSH,  14'h3FFF, 8'hFF, 1'b1, outcome(8'h00, 1'b0, 6'd0)},
    '{OpUnknown, 14'h3FFF, 8'hFF, 1'b1, outcome(8'h00, 1'b0, 6'd0)},
    '{OP_WRITE,  14'h0005, 8'h00, 1'b1, outcome(8'h00, 1'b0, 6'd0)},
    '{OP_READ,   14'h0005, 8'hFF, 1'b1, outcome(8'h00, 1'b0, 6'd0)},
    '{OP_WRITE,  14'h0105, 8'h12, 1'b1, outcome(8'h00, 1'b1, 6'd0)},
    '{OP_READ,   14'h0005, 8'h00, 1'b1, outcome(8'hFF, 1'b0, 6'd0)},
    '{OP_WRITE,  14'h0107, 8'hFF, 1'b0, '0},
    '{OP_WRITE,  14'h0200, 8'hAA, 1'b0, '0},
    '{OP_READ,   14'h0105, 8'h00, 1'b0, '0},
    '{OP_WRITE,  14'h0201, 8'h55, 1'b0, '0},
    '{OP_FLUSH,  14'h0000, 8'h00, 1'b0, '0},
    '{OP_FLUSH,  14'h0201, 8'h00, 1'b1, outcome(8'h00, 1'b0, 6'd0)},
    '{OP_WRITE,  14'h0200, 8'hFF, 1'b0, '0},
    '{OP_FLUSH,  14'h0000, 8'h00, 1'b0, '0},
    '{OP_WRITE,  14'h3F00, 8'h00, 1'b0, '0},
    '{OP_WRITE,  14'h3FFF, 8'h00, 1'b0, '0},
    '{OP_FLUSH,  14'h3FFF, 8'h00, 1'b0, '0},
    '{OP_WRITE,  14'h0000, 8'h01, 1'b0, '0},
    '{OP_FLUSH,  14'h0000, 8'h00, 1'b0, '0},
    '{OP_WRITE,  14'h0000, 8'h03, 1'b0, '0},
    '{OP_READ,   14'h3FFF, 8'h00, 1'b0, '0},
    '{OP_FLUSH,  14'h0000, 8'h00, 1'b0, '0},
    '{OP_READ,   14'h0000, 8'h00, 1'b0, '0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [13:0] byte_address, [21:14] write_data, [23:22] zero
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  // [1:0] opcode
  logic [OpW-1:0]       s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] read_data, [8] page_erased, [9] page_programmed,
  // [10] changes_dropped, [16:11] affected_page, [23:17] zero
  logic [OutTdataW-1:0] m_axis_tdata;

  flash_page_write_back_buffer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Predicted flash contents and the one-page buffer in front of them.
  logic [DataW-1:0] flash_image [FlashDepth];
  logic [DataW-1:0] page_image  [PageBytes];
  logic [PageW-1:0] held_page;
  logic             page_held;
  logic             page_dirty;
  logic             erase_needed;

  flash_result_t    pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      result_count   = 0;
  bit               tx_quiet       = 1'b0;
  bit               rx_quiet       = 1'b0;

  // Byte a read of this address would return right now.
  function automatic logic [DataW-1:0] stored_byte(logic [AddrW-1:0] addr);
    if (page_held && held_page == addr[AddrW-1:OffW])
      return page_image[addr[OffW-1:0]];
    return flash_image[addr];
  endfunction

  // Write the buffer back to flash when it holds changes.
  function automatic void write_back_page(inout flash_result_t res);
    if (!page_held || !page_dirty)
      return;
    for (int i = 0; i < PageBytes; i++) begin
      if (erase_needed)
        flash_image[{held_page, OffW'(i)}] = ErasedByte;
      flash_image[{held_page, OffW'(i)}] &= page_image[i];
    end
    res.erased     = erase_needed;
    res.programmed = 1'b1;
    res.page       = held_page;
    page_dirty     = 1'b0;
    erase_needed   = 1'b0;
  endfunction

  // Apply one accepted word to the predicted state and return its result.
  function automatic flash_result_t apply_flash_op(logic [OpW-1:0] op,
                                                   logic [AddrW-1:0] addr,
                                                   logic [DataW-1:0] data);
    flash_result_t    res;
    logic [PageW-1:0] pg;
    logic [OffW-1:0]  off;
    res = '0;
    pg  = addr[AddrW-1:OffW];
    off = addr[OffW-1:0];
    case (opcode_e'(op))
      OP_READ: res.read_data = stored_byte(addr);
      OP_WRITE: begin
        if (!page_held || held_page != pg) begin
          // Held page zero is replaced without write-back.
          if (page_held && held_page == '0) begin
            res.dropped = 1'b1;
            res.page    = '0;
          end else begin
            write_back_page(res);
          end
          for (int i = 0; i < PageBytes; i++)
            page_image[i] = flash_image[{pg, OffW'(i)}];
          held_page    = pg;
          page_held    = 1'b1;
          page_dirty   = 1'b0;
          erase_needed = 1'b0;
        end
        if ((data & ~page_image[off]) != '0)
          erase_needed = 1'b1;
        if (page_image[off] != data) begin
          page_dirty      = 1'b1;
          page_image[off] = data;
        end
      end
      OP_FLUSH: write_back_page(res);
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: result %0d, %s: got 0x%0h, want 0x%0h", $realtime, result_count,
             what, got, want);
    mismatch_count++;
  endtask

  // Offer one word, wait for its acceptance and record what it must produce.
  task automatic send_word(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] data, input logic typed,
                           input flash_result_t want);
    int            gap;
    flash_result_t predicted;
    if ($urandom_range(0, 39) == 0)
      tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW-AddrW-DataW){1'b0}}, data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_flash_op(op, addr, data);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Reset and stimulus.
  initial begin
    int unsigned      accepted_count;
    int               burst;
    int               kind;
    logic [PageW-1:0] pg;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [OpW-1:0]   op;

    for (int i = 0; i < FlashDepth; i++)
      flash_image[i] = ErasedByte;
    for (int i = 0; i < PageBytes; i++)
      page_image[i] = '0;
    held_page    = '0;
    page_held    = 1'b0;
    page_dirty   = 1'b0;
    erase_needed = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedCount; i++)
      send_word(DirectedRows[i].op, DirectedRows[i].addr, DirectedRows[i].data,
                DirectedRows[i].typed, DirectedRows[i].want);

    // Bursts of work on one page, with stray reads, flushes, unknown opcodes and page switches.
    accepted_count = 0;
    while (accepted_count < RandomItems) begin
      pg    = ($urandom_range(0, 5) == 0) ? '0 : PageW'($urandom_range(0, PageCount - 1));
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst; k++) begin
        kind = $urandom_range(0, 99);
        addr = {pg, OffW'($urandom)};
        data = DataW'($urandom);
        if (kind < 45) begin
          op = OP_WRITE;
          // Some writes leave the byte as it is, some only clear bits.
          case ($urandom_range(0, 3))
            0: data = stored_byte(addr);
            1: data = stored_byte(addr) & data;
            default: ;
          endcase
        end else if (kind < 80) begin
          op = OP_READ;
          if ($urandom_range(0, 3) == 0)
            addr = AddrW'($urandom);
        end else if (kind < 88) begin
          op = OP_FLUSH;
        end else if (kind < 92) begin
          op   = OpUnknown;
          addr = AddrW'($urandom);
        end else begin
          op   = OP_WRITE;
          addr = AddrW'($urandom);
        end
        send_word(op, addr, data, 1'b0, '0);
        if (op != OpUnknown)
          accepted_count++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", pending_results.size(), 0);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, two long holds, and the field check.
  initial begin
    int            gap;
    flash_result_t got;
    flash_result_t want;
    @(posedge rst_ni);
    forever begin
      if (result_count == 300 || result_count == 900) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0)
        rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);

      got = flash_result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data != want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.erased != want.erased)
          report_mismatch("page_erased", got.erased, want.erased);
        if (got.programmed != want.programmed)
          report_mismatch("page_programmed", got.programmed, want.programmed);
        if (got.dropped != want.dropped)
          report_mismatch("changes_dropped", got.dropped, want.dropped);
        if (got.page != want.page)
          report_mismatch("affected_page", got.page, want.page);
        if (got.pad != want.pad)
          report_mismatch("padding", got.pad, want.pad);
      end
      result_count++;
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $realtime, IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

endmodule
